// ===== rtl/pam_pkg.sv =====
`default_nettype none
package pam_pkg;

  localparam int MaxPointsDef = 256;
  localparam int CoordBitsDef = 24;

  localparam logic [47:0] QOne     = 48'd65536;
  localparam logic [63:0] MeanMax  = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [31:0] PairsMax = 32'h0000_7FFF;

  typedef struct packed {
    logic signed [23:0] ref_x;
    logic signed [23:0] ref_y;
    logic signed [23:0] map_x;
    logic signed [23:0] map_y;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic [47:0] mean_ratio;
    logic        result_ok;
    logic [14:0] valid_pairs;
  } out_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PAIR,
    BK_DRAIN,
    BK_DIV,
    BK_OUT
  } back_state_e;

endpackage
`default_nettype wire

// ===== rtl/pairwise_anisomorphism_mean_top.sv =====
// pairwise anisomorphism mean
// input queue: in_i is a transfer when push is high and full is low; one tie
// point per transfer, last_point closes the set
// result queue: while empty is low, out_o holds the oldest result; it is a
// transfer when pop is high. one result per set, on its last point
// a front stage counts points and tags each one; a two-entry queue feeds the
// back end, which pairs the new point with every stored point, one pair per
// cycle, through a bit-per-stage divider of 2*COORD_BITS+16 stages
// a point stored as number n > 1 is paired with the n-1 points stored before
// it, and the back end then waits for the pair pipeline to drain;
// a closing point then runs the mean division when some pair was valid,
// and queues the result
// points beyond MAX_POINTS in a set are ignored
// reset clears both queues, the point count, sum and pair count; the point
// store needs no clearing
// when the receiver stalls, results wait in a two-entry queue and the back
// end holds until there is room; input keeps filling its queue meanwhile
`default_nettype none
module pairwise_anisomorphism_mean_top import pam_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic      full,
  input  wire in_t  in_i,
  output logic      empty,
  input  wire logic pop,
  output out_t      out_o
);

  localparam int QW = $clog2(MAX_POINTS + 1) + $bits(in_t) + 1;

  logic          fq_push, fq_full, fq_pop, fq_empty;
  logic [QW-1:0] fq_wdata, fq_rdata;
  logic          rq_push, rq_full;
  out_t          rq_wdata;
  logic [$bits(out_t)-1:0] rq_rdata;

  pam_front #(.MaxPoints(MAX_POINTS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .in_i     (in_i),
    .q_full_i (fq_full),
    .q_push_o (fq_push),
    .q_data_o (fq_wdata)
  );

  pam_fifo #(.Width(QW)) u_fq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_wdata),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .data_o  (fq_rdata),
    .empty_o (fq_empty)
  );

  pam_back #(.MaxPoints(MAX_POINTS), .CoordBits(COORD_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (fq_empty),
    .q_data_i  (fq_rdata),
    .q_pop_o   (fq_pop),
    .r_full_i  (rq_full),
    .r_push_o  (rq_push),
    .r_data_o  (rq_wdata)
  );

  pam_fifo #(.Width($bits(out_t))) u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_wdata),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_rdata),
    .empty_o (empty)
  );

  assign out_o = out_t'(rq_rdata);

endmodule
`default_nettype wire

// ===== rtl/pam_ram.sv =====
`default_nettype none
module pam_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/pam_fifo.sv =====
`default_nettype none
module pam_fifo #(
  parameter int Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pam_front.sv =====
`default_nettype none
module pam_front import pam_pkg::*; #(
  parameter int MaxPoints = MaxPointsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      full_o,
  input  wire in_t  in_i,
  input  wire logic q_full_i,
  output logic      q_push_o,
  output logic [$clog2(MaxPoints+1)+$bits(in_t):0] q_data_o
);

  localparam int CntW = $clog2(MaxPoints + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] npts;
  logic            store;

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  // points past the store depth are neither stored nor paired
  always_comb begin
    store    = (cnt_q < CntW'(MaxPoints));
    npts     = store ? cnt_q + CntW'(1) : cnt_q;
    cnt_d    = q_push_o ? (in_i.last_point ? '0 : npts) : cnt_q;
    q_data_o = {npts, store, in_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pam_back.sv =====
`default_nettype none
module pam_back import pam_pkg::*; #(
  parameter int MaxPoints = MaxPointsDef,
  parameter int CoordBits = CoordBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_empty_i,
  input  wire logic [$clog2(MaxPoints+1)+$bits(in_t):0] q_data_i,
  output logic      q_pop_o,
  input  wire logic r_full_i,
  output logic      r_push_o,
  output out_t      r_data_o
);

  localparam int CntW  = $clog2(MaxPoints + 1);
  localparam int IdxW  = $clog2(MaxPoints);
  localparam int CB    = CoordBits;
  localparam int PW    = 2 * CB;
  localparam int DS    = PW + 16;
  localparam int PairW = $clog2(MaxPoints * (MaxPoints - 1) / 2 + 1);
  localparam int InW   = $bits(in_t);

  function automatic logic [CB-1:0] adiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic signed [CB:0] d;
    d = signed'({a[CB-1], a}) - signed'({b[CB-1], b});
    if (d < 0) d = -d;
    return d[CB-1:0];
  endfunction

  back_state_e state_q, state_d;

  in_t             item;
  logic [CntW-1:0] item_npts;
  logic            item_store;

  logic [IdxW-1:0] k_q, idx_q;
  logic [4*CB-1:0] cur_q, item_pt, ram_rdata;
  logic            last_q;
  logic [CntW-1:0] npts_q;
  logic [63:0]     sum_q;
  logic [PairW-1:0] pair_q;
  logic            ram_we, issue;

  logic            v1_q, v2_q, v3_q;
  logic [CB-1:0]   ndx_q, ndy_q, mdx_q, mdy_q;
  logic [PW-1:0]   num_q, den_q;

  logic [DS-1:0]   dv_q;
  logic [PW-1:0]   rem_q  [DS];
  logic [DS-1:0]   dvd_q  [DS];
  logic [PW-1:0]   dden_q [DS];
  logic [PW-1:0]   rem_n  [DS];
  logic [DS-1:0]   dvd_n  [DS];
  logic [PW-1:0]   den_in [DS];
  logic            v_in   [DS];
  logic            busy;

  logic [PairW:0]  md_rem_q, md_rem_n, md_t;
  logic [63:0]     md_dvd_q, md_dvd_n;
  logic [6:0]      md_cnt_q;
  logic [63:0]     mean_sat;
  logic [31:0]     pair_ext;
  logic [64:0]     acc;
  out_t            res_q;

  assign item       = in_t'(q_data_i[InW-1:0]);
  assign item_store = q_data_i[InW];
  assign item_npts  = q_data_i[InW+CntW:InW+1];
  assign item_pt    = {item.ref_x[CB-1:0], item.ref_y[CB-1:0],
                       item.map_x[CB-1:0], item.map_y[CB-1:0]};

  pam_ram #(.Width(4 * CB), .Depth(MaxPoints)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IdxW'(item_npts - CntW'(1))),
    .wdata_i (item_pt),
    .raddr_i (k_q),
    .rdata_o (ram_rdata)
  );

  // pair divider, one quotient bit per stage
  for (genvar i = 0; i < DS; i++) begin : g_div
    logic [PW-1:0] rem_in;
    logic [DS-1:0] dvd_in;
    logic [PW:0]   t;
    logic          ge;
    if (i == 0) begin : g_first
      assign rem_in    = '0;
      assign dvd_in    = {num_q, 16'b0};
      assign den_in[i] = den_q;
      assign v_in[i]   = v3_q && (den_q != '0);
    end else begin : g_next
      assign rem_in    = rem_q[i-1];
      assign dvd_in    = dvd_q[i-1];
      assign den_in[i] = dden_q[i-1];
      assign v_in[i]   = dv_q[i-1];
    end
    assign t        = {rem_in, dvd_in[DS-1]};
    assign ge       = (t >= {1'b0, den_in[i]});
    assign rem_n[i] = ge ? PW'(t - {1'b0, den_in[i]}) : t[PW-1:0];
    assign dvd_n[i] = {dvd_in[DS-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DS; i++) begin
      rem_q[i]  <= rem_n[i];
      dvd_q[i]  <= dvd_n[i];
      dden_q[i] <= den_in[i];
    end
  end

  assign busy = v1_q || v2_q || v3_q || (|dv_q);
  assign acc  = {1'b0, sum_q} + 65'(dvd_q[DS-1]);

  // mean divider, one bit a cycle
  always_comb begin
    md_t     = {md_rem_q[PairW-1:0], md_dvd_q[63]};
    if (md_t >= {1'b0, pair_q}) begin
      md_rem_n = md_t - {1'b0, pair_q};
      md_dvd_n = {md_dvd_q[62:0], 1'b1};
    end else begin
      md_rem_n = md_t;
      md_dvd_n = {md_dvd_q[62:0], 1'b0};
    end
    mean_sat = (md_dvd_n > MeanMax) ? MeanMax : md_dvd_n;
    pair_ext = 32'(pair_q);
  end

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    ram_we   = 1'b0;
    issue    = 1'b0;
    r_push_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          ram_we  = item_store;
          state_d = (item_store && item_npts > CntW'(1)) ? BK_PAIR : BK_DRAIN;
        end
      end
      BK_PAIR: begin
        issue = 1'b1;
        if (k_q == idx_q - IdxW'(1)) state_d = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (!busy) begin
          if (!last_q) state_d = BK_IDLE;
          else if (npts_q < CntW'(2) || pair_q == '0) state_d = BK_OUT;
          else state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (md_cnt_q == 7'd63) state_d = BK_OUT;
      end
      BK_OUT: begin
        if (!r_full_i) begin
          r_push_o = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      dv_q    <= '0;
      sum_q   <= '0;
      pair_q  <= '0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      for (int i = 0; i < DS; i++) dv_q[i] <= v_in[i];
      if (r_push_o) begin
        sum_q  <= '0;
        pair_q <= '0;
      end else if (dv_q[DS-1]) begin
        sum_q  <= acc[64] ? '1 : acc[63:0];
        pair_q <= pair_q + PairW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q  <= item_pt;
      last_q <= item.last_point;
      npts_q <= item_npts;
      idx_q  <= IdxW'(item_npts - CntW'(1));
      k_q    <= '0;
    end else if (issue) begin
      k_q <= k_q + IdxW'(1);
    end
    ndx_q <= adiff(cur_q[4*CB-1:3*CB], ram_rdata[4*CB-1:3*CB]);
    ndy_q <= adiff(cur_q[3*CB-1:2*CB], ram_rdata[3*CB-1:2*CB]);
    mdx_q <= adiff(cur_q[2*CB-1:CB], ram_rdata[2*CB-1:CB]);
    mdy_q <= adiff(cur_q[CB-1:0], ram_rdata[CB-1:0]);
    num_q <= ndx_q * mdy_q;
    den_q <= mdx_q * ndy_q;
    if (state_q == BK_DRAIN && !busy) begin
      md_rem_q <= '0;
      md_dvd_q <= sum_q;
      md_cnt_q <= '0;
      if (npts_q < CntW'(2)) begin
        res_q <= '0;
      end else begin
        res_q.mean_ratio  <= QOne;
        res_q.result_ok   <= 1'b1;
        res_q.valid_pairs <= (pair_ext > PairsMax) ? 15'h7FFF : pair_ext[14:0];
      end
    end else if (state_q == BK_DIV) begin
      md_rem_q <= md_rem_n;
      md_dvd_q <= md_dvd_n;
      md_cnt_q <= md_cnt_q + 7'd1;
      if (md_cnt_q == 7'd63) res_q.mean_ratio <= mean_sat[47:0];
    end
  end

  assign r_data_o = res_q;

`ifndef ASSERT_OFF
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == BK_IDLE))
    else $error("item taken while back end busy");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_push_o |-> !r_full_i)
    else $error("result pushed into full queue");
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DRAIN && state_d != BK_DRAIN) |-> !busy)
    else $error("pair pipeline not drained");
  a_no_issue_late: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV || state_q == BK_OUT) |-> !busy)
    else $error("pair in flight after set closed");
`endif

endmodule
`default_nettype wire
